[src/mcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the minimum coin change block
// Table sizes, field widths, register indexes, sequencer step codes and the
// control and status words that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int MAX_AMOUNT = 1023;
  localparam int MAX_COINS  = 6;
  localparam int COIN_REGS  = 6;
  localparam int USABLE_MAX = (MAX_COINS < COIN_REGS) ? MAX_COINS : COIN_REGS;

  // Field widths fixed by the interface.
  localparam int AMT_W  = 10;
  localparam int COIN_W = 10;
  localparam int KCNT_W = 3;
  localparam int OUT_W  = 10;
  localparam int CNT_W  = 11;

  localparam int ADDR_W     = $clog2(MAX_AMOUNT + 1);
  localparam int CMP_W      = (ADDR_W > AMT_W) ? ADDR_W : AMT_W;
  localparam int IDX_W      = $clog2(COIN_REGS + 1);
  localparam int COIN_SEL_W = (COIN_REGS > 1) ? $clog2(COIN_REGS) : 1;

  localparam logic [CNT_W-1:0] NO_WAY    = 11'h7FF;
  localparam logic [CNT_W-1:0] COUNT_CAP = 11'h7FE;
  localparam logic [OUT_W-1:0] OUT_MAX   = 10'd1023;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_COIN_COUNT = 3'd0;
  localparam logic [2:0] REG_COIN_FIRST = 3'd1;
  localparam logic [2:0] REG_COIN_LAST  = 3'd6;

  typedef enum logic [2:0] {
    STEP_WAIT,
    STEP_INIT,
    STEP_COIN,
    STEP_STORE,
    STEP_FINAL,
    STEP_RESULT
  } step_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_REQ,
    COND_T_ZERO,
    COND_COINS_DONE,
    COND_R_BELOW_T,
    COND_OUT_FREE
  } cond_t;

  // One microcode word.
  typedef struct packed {
    logic  in_wait;
    logic  init;
    logic  coin_step;
    logic  store;
    logic  rd_target;
    logic  out_load;
    cond_t cond;
    step_t jmp;
    logic  adv;
  } ctrl_t;

  // Conditions the datapath reports back to the sequencer.
  typedef struct packed {
    logic req;
    logic t_zero;
    logic coins_done;
    logic r_below_t;
    logic out_free;
  } stat_t;

endpackage

[src/min_coin_change.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_coin_change: fewest coins that sum to a requested amount
// Bottom-up table rebuild per request, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one request, the target amount. The out_ stream
//   returns the fewest coins (tdata) and a reachable flag (tuser) for it.
//   Denominations and the number in use are set through the cfg_ APB port;
//   the user must set them only while no request is in flight (not enforced).
// Timing:
//   A request is taken only while the sequencer waits for one. It then
//   rebuilds the table entry by entry: for each entry it steps through the
//   usable coins, with at most one table read per coin through the single
//   read port, closes the coin loop and then stores the entry. A zero target
//   skips the rebuild. In either case the target's entry is then read and
//   the result loaded. The next request can be accepted in the cycle after
//   the result is loaded; none is taken while one is in flight.
// Reset and stall:
//   Reset returns the sequencer to waiting, clears out_tvalid and sets the
//   coin registers to 1. The table needs no clearing, as each entry is
//   written before it is read. The result waits in an output register; if
//   still not taken when the next is ready, the sequencer holds until it is.
// ----------------------------------------------------------------------------
module min_coin_change (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request stream. tdata: [9:0] target_amount.
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,
  // Result stream. tdata: [9:0] min_coins. tuser: [0] reachable.
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,
  output logic [0:0]                 out_tuser,
  // Configuration port.
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mcc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mcc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mcc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import mcc_pkg::*;

  ctrl_t ctl;
  stat_t stat;

  // Configuration registers.
  logic [KCNT_W-1:0] coin_count_r;
  logic [COIN_W-1:0] coin_value_r [COIN_REGS];
  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic [2:0]        cfg_coin_off;

  // Datapath.
  logic [AMT_W-1:0]  target_r;
  logic              bad_r;
  logic [ADDR_W-1:0] r_r;
  logic [ADDR_W-1:0] r_nxt;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  i_nxt;
  logic [CNT_W-1:0]  best_r;
  logic [CNT_W-1:0]  best_nxt;
  logic              pend_r;
  logic [IDX_W-1:0]  usable_k;
  logic [COIN_W-1:0] coin_cur;
  logic              coin_issue;
  logic              in_accept;

  logic [CNT_W-1:0]  table_mem [MAX_AMOUNT + 1];
  logic [CNT_W-1:0]  rdata_r;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;

  logic [CNT_W:0]    cand_sum;
  logic [CNT_W-1:0]  cand;
  logic              take;

  logic              out_valid_r;
  logic [OUT_W-1:0]  min_r;
  logic              reach_r;
  logic              out_free;
  logic [OUT_W-1:0]  res_min;
  logic              res_reach;

  mcc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // ---------------- configuration port ----------------
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx      = cfg_paddr[4:2];
  assign cfg_coin_off = 3'(cfg_idx - REG_COIN_FIRST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coin_count_r <= KCNT_W'(1);
      for (int j = 0; j < COIN_REGS; j++) begin
        coin_value_r[j] <= COIN_W'(1);
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_COIN_COUNT) begin
        coin_count_r <= cfg_pwdata[KCNT_W-1:0];
      end
      for (int j = 0; j < COIN_REGS; j++) begin
        if (cfg_idx == 3'(REG_COIN_FIRST + 3'(j))) begin
          coin_value_r[j] <= cfg_pwdata[COIN_W-1:0];
        end
      end
    end
  end

  always_comb begin
    priority if (cfg_idx == REG_COIN_COUNT) begin
      cfg_prdata = CFG_DW'(coin_count_r);
    end else if (cfg_idx >= REG_COIN_FIRST && cfg_idx <= REG_COIN_LAST) begin
      cfg_prdata = CFG_DW'(coin_value_r[COIN_SEL_W'(cfg_coin_off)]);
    end else begin
      cfg_prdata = '0;
    end
  end

  // ---------------- coin selection ----------------
  assign usable_k = (coin_count_r > KCNT_W'(USABLE_MAX)) ? IDX_W'(USABLE_MAX)
                                                         : IDX_W'(coin_count_r);
  assign coin_cur = (i_r < IDX_W'(COIN_REGS)) ? coin_value_r[COIN_SEL_W'(i_r)] : '0;

  // A zero coin, or one larger than the amount, issues no read.
  assign coin_issue = ctl.coin_step && (i_r < usable_k) && (coin_cur != '0) &&
                      (CMP_W'(coin_cur) <= CMP_W'(r_r));

  assign in_tready = ctl.in_wait;
  assign in_accept = in_tvalid && in_tready;

  // ---------------- table memory ----------------
  assign rd_en   = coin_issue || ctl.rd_target;
  assign rd_addr = ctl.rd_target ? ADDR_W'(CMP_W'(target_r))
                                 : ADDR_W'(CMP_W'(r_r) - CMP_W'(coin_cur));
  assign wr_en   = (ctl.init && !bad_r) || ctl.store;
  assign wr_addr = ctl.store ? r_r : '0;
  assign wr_data = ctl.store ? best_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= table_mem[rd_addr];
    end
  end

  // ---------------- running minimum ----------------
  // The read issued in one coin cycle is folded into the minimum in the next.
  assign cand_sum = {1'b0, rdata_r} + (CNT_W + 1)'(1);
  assign cand     = (cand_sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : cand_sum[CNT_W-1:0];
  assign take     = pend_r && (rdata_r != NO_WAY) && (cand < best_r);

  always_comb begin
    priority if (ctl.init || ctl.store) begin
      best_nxt = NO_WAY;
    end else if (take) begin
      best_nxt = cand;
    end else begin
      best_nxt = best_r;
    end

    priority if (ctl.init || ctl.store) begin
      i_nxt = '0;
    end else if (ctl.coin_step && (i_r < usable_k)) begin
      i_nxt = IDX_W'(i_r + IDX_W'(1));
    end else begin
      i_nxt = i_r;
    end

    priority if (ctl.init) begin
      r_nxt = ADDR_W'(1);
    end else if (ctl.store) begin
      r_nxt = ADDR_W'(r_r + ADDR_W'(1));
    end else begin
      r_nxt = r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= coin_issue;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    i_r    <= i_nxt;
    r_r    <= r_nxt;
    if (in_accept) begin
      target_r <= in_tdata[AMT_W-1:0];
      bad_r    <= (32'(in_tdata[AMT_W-1:0]) > 32'(MAX_AMOUNT));
    end
  end

  // ---------------- status to the sequencer ----------------
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    stat.req        = in_tvalid;
    stat.t_zero     = bad_r || (target_r == '0);
    stat.coins_done = (i_r >= usable_k);
    stat.r_below_t  = (CMP_W'(r_r) < CMP_W'(target_r));
    stat.out_free   = out_free;
  end

  // ---------------- result register ----------------
  always_comb begin
    if (bad_r || (rdata_r == NO_WAY)) begin
      res_min   = '0;
      res_reach = 1'b0;
    end else begin
      res_min   = (rdata_r > CNT_W'(OUT_MAX)) ? OUT_MAX : rdata_r[OUT_W-1:0];
      res_reach = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load && out_free) begin
      min_r   <= res_min;
      reach_r <= res_reach;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(min_r);
  assign out_tuser  = reach_r;

  // ---------------- assertions ----------------
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("request accepted while one is in flight");

  a_pend_in_coin: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ctl.coin_step)
    else $error("table read returned outside the coin loop");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.out_load && out_free) |=> out_tvalid)
    else $error("loaded result not presented");

  a_r_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.coin_step |-> (CMP_W'(r_r) <= CMP_W'(target_r)) && (r_r != '0))
    else $error("table index outside one to target");

  a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.coin_step |-> (i_r <= usable_k))
    else $error("coin index ran past the usable coins");

endmodule

[src/mcc_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_seq: microcode sequencer of the minimum coin change block
// A step counter walks a small read-only program; each word drives the
// datapath strobes and names a jump condition and its destination.
// ----------------------------------------------------------------------------
module mcc_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  mcc_pkg::stat_t stat,
  output mcc_pkg::ctrl_t ctl
);
  import mcc_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  cond_hit;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      STEP_WAIT: begin
        w.in_wait = 1'b1;
        w.cond    = COND_REQ;
        w.jmp     = STEP_INIT;
      end
      STEP_INIT: begin
        w.init = 1'b1;
        w.cond = COND_T_ZERO;
        w.jmp  = STEP_FINAL;
        w.adv  = 1'b1;
      end
      STEP_COIN: begin
        w.coin_step = 1'b1;
        w.cond      = COND_COINS_DONE;
        w.jmp       = STEP_STORE;
      end
      STEP_STORE: begin
        w.store = 1'b1;
        w.cond  = COND_R_BELOW_T;
        w.jmp   = STEP_COIN;
        w.adv   = 1'b1;
      end
      STEP_FINAL: begin
        w.rd_target = 1'b1;
        w.cond      = COND_NEVER;
        w.jmp       = STEP_WAIT;
        w.adv       = 1'b1;
      end
      STEP_RESULT: begin
        w.out_load = 1'b1;
        w.cond     = COND_OUT_FREE;
        w.jmp      = STEP_WAIT;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.jmp  = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    ctl = ucode(pc_r);
  end

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:      cond_hit = 1'b0;
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_REQ:        cond_hit = stat.req;
      COND_T_ZERO:     cond_hit = stat.t_zero;
      COND_COINS_DONE: cond_hit = stat.coins_done;
      COND_R_BELOW_T:  cond_hit = stat.r_below_t;
      COND_OUT_FREE:   cond_hit = stat.out_free;
      default:         cond_hit = 1'b1;
    endcase
    if (cond_hit) begin
      pc_nxt = ctl.jmp;
    end else if (ctl.adv) begin
      pc_nxt = step_t'(3'(pc_r + 3'd1));
    end else begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
